FILE: rtl/msbsb_pkg.sv
// Shared types, codes and helpers for the MSB-first bit stack buffer.
`default_nettype none

package msbsb_pkg;

    localparam int CMD_W    = 3;
    localparam int IDX_W    = 12;
    localparam int CNT_W    = 4;
    localparam int STATUS_W = 2;
    localparam int LEN_OUT_W = 13;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SET  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

    localparam logic [7:0] TOP_BIT = 8'h80;

    // Decoded request held for the memory update cycle.
    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [STATUS_W-1:0] status;
        logic [2:0]          sh;
        logic                a_odd;
        logic                span;
        logic [7:0]          bits;
        logic                val;
        logic [CNT_W-1:0]    nvalid;
    } op_t;

    typedef struct packed {
        logic       we_even;
        logic       we_odd;
        logic [7:0] wd_even;
        logic [7:0] wd_odd;
    } wr_t;

    // Mask of the upper n bits of a byte, n from 0 to 8.
    function automatic logic [7:0] hi_mask(input logic [CNT_W-1:0] n);
        logic [15:0] m;
        m = 16'hFF00 >> n;
        return m[7:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/msbsb_merge.sv
// Update cycle: merges the read byte with the request and forms the result.
`default_nettype none

module msbsb_merge
    import msbsb_pkg::*;
(
    input  var op_t        op,
    input  wire logic [7:0] even_q,
    input  wire logic [7:0] odd_q,
    output var wr_t        wr,
    output logic           bit_out,
    output logic [7:0]     byte_out
);

    logic [7:0]  b0;
    logic [15:0] pair;
    logic [2:0]  bpos;
    logic [7:0]  new0;
    logic [7:0]  new1;
    logic        we0;
    logic        we1;

    always_comb
    begin
        b0       = op.a_odd ? odd_q : even_q;
        pair     = {op.bits, 8'h00} >> op.sh;
        bpos     = 3'd7 - op.sh;
        new0     = b0;
        new1     = pair[7:0];
        we0      = 1'b0;
        we1      = 1'b0;
        bit_out  = 1'b0;
        byte_out = 8'h00;
        if (op.status == ST_OK)
        begin
            unique case (op.cmd)
                CMD_PUSH:
                begin
                    // bits at or past the length are stale in memory: drop them
                    new0 = (b0 & hi_mask({1'b0, op.sh})) | pair[15:8];
                    we0  = 1'b1;
                    we1  = op.span;
                end
                CMD_POP, CMD_GET:
                begin
                    bit_out = b0[bpos];
                end
                CMD_SET:
                begin
                    new0       = b0;
                    new0[bpos] = op.val;
                    we0        = 1'b1;
                end
                CMD_READ:
                begin
                    byte_out = b0 & hi_mask(op.nvalid);
                end
                default:
                begin
                    bit_out = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        wr.we_even = op.a_odd ? we1 : we0;
        wr.we_odd  = op.a_odd ? we0 : we1;
        wr.wd_even = op.a_odd ? new1 : new0;
        wr.wd_odd  = op.a_odd ? new0 : new1;
    end

endmodule

`default_nettype wire

FILE: rtl/msb_first_bit_stack_buffer.sv
// Top level: request decode, banked byte store, length register, result register.
// Request and store read byte are registered, then the merged result is registered.
// A new request waits for the last write-back and for any held result to be taken.
// A push spanning two bytes writes the even and odd banks in the same cycle.
// Reset clears the length and handshake state; no clearing pass runs on the store.
// Store bits at or past the length are masked on every read, so they never show.
`default_nettype none

module msb_first_bit_stack_buffer
    import msbsb_pkg::*;
#(
    parameter int CAP_BITS = 4096
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // bit_index[11:0], data_byte[19:12], bit_count[23:20], bit_value[24], zero[31:25]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // cmd[2:0]
    input  wire logic [CMD_W-1:0]     s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // bit_out[0], byte_out[8:1], length_bits[21:9], status[23:22]
    output logic [M_TDATA_W-1:0]      m_tdata
);

    localparam int STORE_BYTES = CAP_BITS / 8;
    localparam int EVEN_DEPTH  = (STORE_BYTES + 1) / 2;
    localparam int ODD_DEPTH   = STORE_BYTES / 2;
    localparam int EAW         = $clog2(EVEN_DEPTH);
    localparam int OAW         = $clog2(ODD_DEPTH);
    localparam int LW          = $clog2(CAP_BITS + 1);
    localparam int PW          = (LW > IDX_W) ? LW : IDX_W;
    localparam logic [LW:0]   CAP_L  = (LW+1)'(CAP_BITS);
    localparam logic [PW-1:0] SB_P   = PW'(STORE_BYTES);

    logic [7:0] even_mem [EVEN_DEPTH];
    logic [7:0] odd_mem  [ODD_DEPTH];
    logic [7:0] even_q;
    logic [7:0] odd_q;

    logic                 busy_reg;
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [LW-1:0]        len_reg;
    logic [LW-1:0]        len_next;
    op_t                  op_reg;
    op_t                  op_next;
    logic [EAW-1:0]       ea_reg;
    logic [OAW-1:0]       oa_reg;

    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
    logic [CNT_W-1:0] cnt;
    logic             val;
    logic             accept;

    logic [PW-1:0]   idx_w;
    logic [PW-1:0]   len_w;
    logic [PW-1:0]   pos;
    logic [PW-1:0]   abyte;
    logic [PW-1:0]   ea_full;
    logic [PW-1:0]   oa_full;
    logic [PW-1:0]   full_bytes;
    logic [LW:0]     sum;
    logic [CNT_W-1:0] span_sum;

    wr_t        wr;
    logic       bit_out;
    logic [7:0] byte_out;
    logic [LW+LEN_OUT_W-1:0] len_ext;

    assign cmd  = s_tuser;
    assign idx  = s_tdata[11:0];
    assign data = s_tdata[19:12];
    assign cnt  = s_tdata[23:20];
    assign val  = s_tdata[24];

    assign s_tready = !busy_reg && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        idx_w      = PW'(idx);
        len_w      = PW'(len_reg);
        full_bytes = len_w >> 3;
        sum        = (LW+1)'(len_reg) + (LW+1)'(cnt);
        unique case (cmd)
            CMD_PUSH: pos = len_w;
            CMD_POP:  pos = len_w - PW'(1);
            default:  pos = idx_w;
        endcase
        abyte    = (cmd == CMD_READ) ? idx_w : (pos >> 3);
        ea_full  = (abyte + PW'(1)) >> 1;
        oa_full  = abyte >> 1;
        span_sum = {1'b0, pos[2:0]} + cnt;

        op_next.cmd    = cmd;
        op_next.sh     = pos[2:0];
        op_next.a_odd  = abyte[0];
        op_next.span   = span_sum > 4'd8;
        op_next.bits   = data & hi_mask(cnt);
        op_next.val    = val;
        if (idx_w < full_bytes)
            op_next.nvalid = 4'd8;
        else if (idx_w == full_bytes)
            op_next.nvalid = {1'b0, len_w[2:0]};
        else
            op_next.nvalid = 4'd0;

        op_next.status = ST_OK;
        len_next       = len_reg;
        unique case (cmd)
            CMD_PUSH:
            begin
                priority if (cnt == 4'd0 || cnt > 4'd8)
                    op_next.status = ST_RANGE;
                else if (sum > CAP_L)
                    op_next.status = ST_OVERFLOW;
                else
                    len_next = sum[LW-1:0];
            end
            CMD_POP:
            begin
                if (len_reg == '0)
                    op_next.status = ST_RANGE;
                else
                    len_next = len_reg - LW'(1);
            end
            CMD_GET, CMD_SET:
            begin
                if (idx_w >= len_w)
                    op_next.status = ST_RANGE;
            end
            CMD_READ:
            begin
                if (idx_w >= SB_P)
                    op_next.status = ST_RANGE;
            end
            default:
            begin
                op_next.status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && op_next.status == ST_OK && !abyte[0])
            even_q <= even_mem[ea_full[EAW-1:0]];
        if (busy_reg && wr.we_even)
            even_mem[ea_reg] <= wr.wd_even;
    end

    always_ff @(posedge clk)
    begin
        if (accept && op_next.status == ST_OK && abyte[0])
            odd_q <= odd_mem[oa_full[OAW-1:0]];
        if (busy_reg && wr.we_odd)
            odd_mem[oa_reg] <= wr.wd_odd;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= op_next;
            ea_reg <= ea_full[EAW-1:0];
            oa_reg <= oa_full[OAW-1:0];
        end
    end

    msbsb_merge u_merge (
        .op       (op_reg),
        .even_q   (even_q),
        .odd_q    (odd_q),
        .wr       (wr),
        .bit_out  (bit_out),
        .byte_out (byte_out)
    );

    assign len_ext = {{LEN_OUT_W{1'b0}}, len_reg};

    always_ff @(posedge clk)
    begin
        if (busy_reg)
            m_tdata_reg <= {op_reg.status, len_ext[LEN_OUT_W-1:0], byte_out, bit_out};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            len_reg      <= '0;
        end
        else
        begin
            busy_reg <= accept;
            if (accept)
                len_reg <= len_next;
            if (busy_reg)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("request accepted while previous one in flight");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> m_tvalid)
        else $error("no result after update cycle");

    a_len_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (LW+1)'(len_reg) <= CAP_L)
        else $error("length beyond capacity");

    a_dual_write_push: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && wr.we_even && wr.we_odd) |-> (op_reg.cmd == CMD_PUSH))
        else $error("two-byte write outside push");

    a_len_held_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op_next.status != ST_OK) |=> $stable(len_reg))
        else $error("length changed on rejected request");

endmodule

`default_nettype wire
